[rtl/med_pkg.sv]
// Shared types and constants for the multilevel error-diffusion dither block.
// Holds the item structs, command and register codes, and the control structs.
// Depends on nothing; every other RTL file but med_ram imports it.
`default_nettype none

package med_pkg;

  // Command codes carried in the cmd field of an input item.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_PROCESS = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Configuration register indexes (byte address = 8 * index).
  localparam int          CFG_ADDR_W   = 6;
  localparam int          CFG_DATA_W   = 64;
  localparam logic [2:0]  REG_WIDTH    = 3'd0;
  localparam logic [2:0]  REG_HEIGHT   = 3'd1;
  localparam logic [2:0]  REG_MASK_0   = 3'd2;
  localparam logic [2:0]  REG_MASK_1   = 3'd3;
  localparam logic [2:0]  REG_MASK_2   = 3'd4;
  localparam logic [2:0]  REG_MASK_3   = 3'd5;

  // Register reset values and level mask geometry.
  localparam logic [8:0] FRAME_SIZE_RESET = 9'd256;
  localparam int         LEVEL_BITS       = 256;
  localparam int         CHUNK_BITS       = 64;
  localparam int         CHUNK_COUNT      = LEVEL_BITS / CHUNK_BITS;

  // Diffusion weights in sixteenths.
  localparam logic signed [4:0] WGT_RIGHT       = 5'sd7;
  localparam logic signed [4:0] WGT_BELOW_LEFT  = 5'sd3;
  localparam logic signed [4:0] WGT_BELOW       = 5'sd5;
  localparam logic signed [4:0] WGT_BELOW_RIGHT = 5'sd1;
  localparam int                WGT_SHIFT       = 4;
  localparam logic [7:0]        PIXEL_MAX       = 8'd255;

  // Input item: command and pixel to store.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pixel_value;
  } cmd_item_t;

  // Result item: chosen level and end-of-frame flag.
  typedef struct packed {
    logic [7:0] out_pixel;
    logic       last_of_frame;
  } res_item_t;

  // Register file contents seen by the datapath.
  typedef struct packed {
    logic [8:0]            frame_width;
    logic [8:0]            frame_height;
    logic [LEVEL_BITS-1:0] level_mask;
  } cfg_t;

  // Level search request and response.
  typedef struct packed {
    logic       start;
    logic [7:0] pixel;
  } lvl_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] level;
  } lvl_rsp_t;

endpackage

`default_nettype wire

[rtl/med_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// A read in the cycle after a write to the same entry returns the new data.
// No dependencies.
`default_nettype none

module med_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/med_cfg.sv]
// APB-style register file: frame size and the 256-bit output level mask.
// Depends on med_pkg for register codes, reset values and the cfg_t struct.
`default_nettype none

module med_cfg
  import med_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FRAME_SIZE_RESET;
      cfg.frame_height <= FRAME_SIZE_RESET;
      cfg.level_mask   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg.frame_width  <= pwdata[8:0];
        REG_HEIGHT: cfg.frame_height <= pwdata[8:0];
        REG_MASK_0: cfg.level_mask[0*CHUNK_BITS +: CHUNK_BITS] <= pwdata;
        REG_MASK_1: cfg.level_mask[1*CHUNK_BITS +: CHUNK_BITS] <= pwdata;
        REG_MASK_2: cfg.level_mask[2*CHUNK_BITS +: CHUNK_BITS] <= pwdata;
        REG_MASK_3: cfg.level_mask[3*CHUNK_BITS +: CHUNK_BITS] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {55'd0, cfg.frame_width};
      REG_HEIGHT: prdata = {55'd0, cfg.frame_height};
      REG_MASK_0: prdata = cfg.level_mask[0*CHUNK_BITS +: CHUNK_BITS];
      REG_MASK_1: prdata = cfg.level_mask[1*CHUNK_BITS +: CHUNK_BITS];
      REG_MASK_2: prdata = cfg.level_mask[2*CHUNK_BITS +: CHUNK_BITS];
      REG_MASK_3: prdata = cfg.level_mask[3*CHUNK_BITS +: CHUNK_BITS];
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/med_level_search.sv]
// Iterative nearest-level finder: scans the level mask one 64-bit chunk per
// cycle for the closest levels below and above a pixel. Depends on med_pkg.
`default_nettype none

module med_level_search
  import med_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [LEVEL_BITS-1:0] mask,
  input  wire lvl_req_t              req,
  output lvl_rsp_t                   rsp
);

  logic                  busy;
  logic [2:0]            cnt;
  logic                  hi_found;
  logic [7:0]            pix;
  logic [7:0]            lo;
  logic [7:0]            hi;
  logic [LEVEL_BITS-1:0] eff_mask;
  logic [CHUNK_BITS-1:0] chunk_bits;
  logic [CHUNK_BITS-1:0] lo_cand;
  logic [CHUNK_BITS-1:0] hi_cand;
  logic [5:0]            lo_idx;
  logic [5:0]            hi_idx;
  logic [1:0]            chunk;
  logic [7:0]            dist_lo;
  logic [7:0]            dist_hi;

  assign chunk = cnt[1:0];

  // Levels 0 and 255 are always present.
  always_comb begin
    eff_mask = mask;
    eff_mask[0] = 1'b1;
    eff_mask[LEVEL_BITS-1] = 1'b1;
  end

  assign chunk_bits = eff_mask[{chunk, 6'd0} +: CHUNK_BITS];

  // Candidate bits at or below and at or above the pixel within this chunk.
  always_comb begin
    for (int j = 0; j < CHUNK_BITS; j++) begin
      lo_cand[j] = chunk_bits[j] &&
                   ((chunk < pix[7:6]) || ((chunk == pix[7:6]) && (6'(j) <= pix[5:0])));
      hi_cand[j] = chunk_bits[j] &&
                   ((chunk > pix[7:6]) || ((chunk == pix[7:6]) && (6'(j) >= pix[5:0])));
    end
  end

  // Highest lower candidate and lowest upper candidate.
  always_comb begin
    lo_idx = '0;
    for (int j = 0; j < CHUNK_BITS; j++) begin
      if (lo_cand[j]) lo_idx = 6'(j);
    end
  end

  always_comb begin
    hi_idx = '0;
    for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
      if (hi_cand[j]) hi_idx = 6'(j);
    end
  end

  // Distances from the pixel; a tie goes to the upper level.
  assign dist_lo = pix - lo;
  assign dist_hi = hi - pix;

  // Scan chunks upward, then pick the nearer level.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      hi_found <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.start && busy && (cnt == 3'(CHUNK_COUNT));
      if (req.start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        hi_found <= 1'b0;
      end else if (busy) begin
        if (cnt == 3'(CHUNK_COUNT)) begin
          busy      <= 1'b0;
          rsp.level <= (dist_lo < dist_hi) ? lo : hi;
        end else begin
          cnt <= cnt + 3'd1;
          if ((|hi_cand) && !hi_found) begin
            hi_found <= 1'b1;
          end
        end
      end
    end
  end

  // Search datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      pix <= req.pixel;
    end else if (busy && (cnt != 3'(CHUNK_COUNT))) begin
      if (|lo_cand) lo <= {chunk, lo_idx};
      if ((|hi_cand) && !hi_found) hi <= {chunk, hi_idx};
    end
  end

endmodule

`default_nettype wire

[rtl/multilevel_error_diffusion_dither_core.sv]
// Multilevel error-diffusion dither core (frame store in one synchronous RAM).
// Load, restart and no-op items are handled in ST_IDLE. A process item holds
// the block for a pixel read, a 4-chunk level scan, and four neighbor
// read-modify-writes pipelined through the RAM's one read and one write port.
// The result is registered, so the next item is accepted while it waits.
// Reset clears state, counters and res_valid, not the datapath or frame store.
`default_nettype none

module multilevel_error_diffusion_dither_core
  import med_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire cmd_item_t             cmd_data,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output res_item_t                  res_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int TW    = WW + HW;
  localparam int PW    = RW + WW;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ADDR   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SEARCH = 6'b001000,
    ST_SPREAD = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic [AW-1:0] load_pos;
  logic [RW-1:0] row_cnt;
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic          cur_last;
  logic          en_right;
  logic          en_below;
  logic          en_left;
  logic [AW-1:0] pix_addr;
  logic [7:0]    pixel_q;
  logic [7:0]    level_q;
  logic [2:0]    step;
  logic signed [8:0] share_q [4];

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [TW-1:0] total;
  logic [AW-1:0] load_wr_pos;
  logic [TW-1:0] load_inc;
  logic [AW-1:0] load_next;
  logic          wrap;
  logic [RW-1:0] r_sel;
  logic [CW-1:0] c_sel;
  logic [WW-1:0] c_inc;
  logic [HW-1:0] r_inc;
  logic [PW-1:0] row_prod;
  logic [AW-1:0] pix_addr_calc;
  logic [AW-1:0] nb_addr [4];
  logic [3:0]    nb_en;
  logic [1:0]    wr_idx;
  logic signed [8:0]  err;
  logic signed [10:0] sum;
  logic [7:0]    wr_value;
  logic          accept;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  lvl_req_t lvl_req;
  lvl_rsp_t lvl_rsp;

  // Share of the error for one neighbor, truncated toward zero.
  function automatic logic signed [8:0] share(input logic signed [8:0] e,
                                              input logic signed [4:0] wgt);
    logic signed [12:0] prod;
    logic signed [12:0] adj;
    prod = 13'(e) * 13'(wgt);
    adj  = prod[12] ? prod + 13'sd15 : prod;
    return 9'(adj >>> WGT_SHIFT);
  endfunction

  // Register file.
  med_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame store.
  med_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Nearest-level search unit.
  med_level_search u_search (
    .clk  (clk),
    .rst  (rst),
    .mask (cfg.level_mask),
    .req  (lvl_req),
    .rsp  (lvl_rsp)
  );

  assign lvl_req.start = (state == ST_READ);
  assign lvl_req.pixel = ram_rdata;

  // Effective frame size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (cfg.frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg.frame_height);
    end
  end

  assign total = TW'(eff_w) * TW'(eff_h);

  // Load position with wrap at the frame end.
  assign load_wr_pos = (TW'(load_pos) >= total) ? '0 : load_pos;
  assign load_inc    = TW'(load_wr_pos) + TW'(1);
  assign load_next   = (load_inc >= total) ? '0 : AW'(load_inc);

  // Process position, restarting when outside the current frame.
  assign wrap  = (HW'(row_cnt) >= eff_h) || (WW'(col_cnt) >= eff_w);
  assign r_sel = wrap ? '0 : row_cnt;
  assign c_sel = wrap ? '0 : col_cnt;
  assign c_inc = WW'(c_sel) + WW'(1);
  assign r_inc = HW'(r_sel) + HW'(1);

  assign accept    = cmd_valid && cmd_ready;
  assign cmd_ready = (state == ST_IDLE) && !rst;

  // Pixel address and its neighbors.
  assign row_prod      = PW'(cur_row) * PW'(eff_w);
  assign pix_addr_calc = AW'(row_prod) + AW'(cur_col);
  assign nb_addr[0]    = pix_addr + AW'(1);
  assign nb_addr[1]    = pix_addr + AW'(eff_w) - AW'(1);
  assign nb_addr[2]    = pix_addr + AW'(eff_w);
  assign nb_addr[3]    = pix_addr + AW'(eff_w) + AW'(1);
  assign nb_en         = {en_below && en_right, en_below, en_below && en_left, en_right};

  // Error of the chosen level and read-modify-write value.
  assign err      = $signed({1'b0, pixel_q}) - $signed({1'b0, lvl_rsp.level});
  assign wr_idx   = 2'(step - 3'd1);
  assign sum      = $signed({3'b000, ram_rdata}) + {{2{share_q[wr_idx][8]}}, share_q[wr_idx]};
  always_comb begin
    if (sum < 0) begin
      wr_value = '0;
    end else if (sum > $signed({3'b000, PIXEL_MAX})) begin
      wr_value = PIXEL_MAX;
    end else begin
      wr_value = sum[7:0];
    end
  end

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_wr_pos;
    ram_wdata = cmd_data.pixel_value;
    ram_raddr = pix_addr;
    if (state == ST_IDLE) begin
      ram_we = accept && (cmd_data.cmd == CMD_LOAD);
    end
    if (state == ST_ADDR) begin
      ram_raddr = pix_addr_calc;
    end
    if (state == ST_SPREAD) begin
      if (step != 3'd4) begin
        ram_raddr = nb_addr[step[1:0]];
      end
      if (step != 3'd0) begin
        ram_we    = nb_en[wr_idx];
        ram_waddr = nb_addr[wr_idx];
        ram_wdata = wr_value;
      end
    end
  end

  // Control sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      load_pos  <= '0;
      row_cnt   <= '0;
      col_cnt   <= '0;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != ST_FIN)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd_data.cmd)
              CMD_LOAD: begin
                load_pos <= load_next;
              end
              CMD_PROCESS: begin
                state <= ST_ADDR;
                if (c_inc < eff_w) begin
                  col_cnt <= CW'(c_inc);
                  row_cnt <= r_sel;
                end else begin
                  col_cnt <= '0;
                  row_cnt <= (r_inc < eff_h) ? RW'(r_inc) : '0;
                end
              end
              CMD_RESTART: begin
                load_pos <= '0;
                row_cnt  <= '0;
                col_cnt  <= '0;
              end
              CMD_NOP: ;
              default: ;
            endcase
          end
        end
        ST_ADDR: begin
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (lvl_rsp.done) begin
            step  <= '0;
            state <= ST_SPREAD;
          end
        end
        ST_SPREAD: begin
          step <= step + 3'd1;
          if (step == 3'd4) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Per-item datapath registers.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept) begin
      cur_row  <= r_sel;
      cur_col  <= c_sel;
      cur_last <= (HW'(r_sel) == eff_h - HW'(1)) && (WW'(c_sel) == eff_w - WW'(1));
      en_right <= (c_inc < eff_w);
      en_below <= (r_inc < eff_h);
      en_left  <= (c_sel != '0);
    end
    if (state == ST_ADDR) begin
      pix_addr <= pix_addr_calc;
    end
    if (state == ST_READ) begin
      pixel_q <= ram_rdata;
    end
    if ((state == ST_SEARCH) && lvl_rsp.done) begin
      level_q    <= lvl_rsp.level;
      share_q[0] <= share(err, WGT_RIGHT);
      share_q[1] <= share(err, WGT_BELOW_LEFT);
      share_q[2] <= share(err, WGT_BELOW);
      share_q[3] <= share(err, WGT_BELOW_RIGHT);
    end
    if ((state == ST_FIN) && (!res_valid || res_ready)) begin
      res_data.out_pixel     <= level_q;
      res_data.last_of_frame <= cur_last;
    end
  end

endmodule

`default_nettype wire

[dv/multilevel_error_diffusion_dither_core_test.sv]
// Self-checking testbench for the multilevel error-diffusion dither core.
// Drives load, process, restart and no-op items plus APB register writes, and
// checks every level against the in-bench model or a pinned one; needs all RTL.
module multilevel_error_diffusion_dither_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import med_pkg::*;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 256;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ITEM_TARGET = 400;
  localparam int MAX_GAP     = 6;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 20;
  localparam int SMALL_FRAME = 64;

  // One row of the directed table: the item, and a level typed in by hand
  // where it is obvious at a glance.
  typedef struct packed {
    cmd_item_t item;
    logic      pinned;
    res_item_t want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_ready;
  cmd_item_t             cmd_data = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  res_item_t             res_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Model state: frame store, counters and register copies.
  logic [7:0]            pix_mem [0:STORE_DEPTH-1];
  bit                    ever_written [0:STORE_DEPTH-1];
  int                    loaded_below = 0;
  int                    load_pos = 0;
  int                    proc_row = 0;
  int                    proc_col = 0;
  logic [8:0]            frame_cols = FRAME_SIZE_RESET;
  logic [8:0]            frame_rows = FRAME_SIZE_RESET;
  logic [LEVEL_BITS-1:0] level_set = '0;

  res_item_t pending_levels [$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        levels_checked = 0;
  int        frame_ends = 0;
  bit        no_gaps = 1'b0;
  bit        hold_request = 1'b0;

  // Tie case, extremes, wrap, restart and ignored no-op on a 3x2 frame with
  // levels 0, 100 and 255.
  step_row_t directed_rows [21] = '{
    '{'{CMD_LOAD,    8'd50},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_LOAD,    8'd60},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_LOAD,    8'd255}, 1'b0, '{8'd0,   1'b0}},
    '{'{CMD_LOAD,    8'd0},   1'b0, '{8'd0,   1'b0}},
    '{'{CMD_LOAD,    8'd255}, 1'b0, '{8'd0,   1'b0}},
    '{'{CMD_LOAD,    8'd254}, 1'b0, '{8'd0,   1'b0}},
    '{'{CMD_PROCESS, 8'd0},   1'b1, '{8'd100, 1'b0}},
    '{'{CMD_PROCESS, 8'hFF},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_NOP,     8'hA5},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_PROCESS, 8'h0F},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_PROCESS, 8'hF0},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_PROCESS, 8'h00},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_PROCESS, 8'hFF},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_PROCESS, 8'h55},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_RESTART, 8'hFF},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_LOAD,    8'd0},   1'b0, '{8'd0,   1'b0}},
    '{'{CMD_LOAD,    8'd255}, 1'b0, '{8'd0,   1'b0}},
    '{'{CMD_PROCESS, 8'hAA},  1'b1, '{8'd0,   1'b0}},
    '{'{CMD_PROCESS, 8'h00},  1'b1, '{8'd255, 1'b0}},
    '{'{CMD_LOAD,    8'h5A},  1'b0, '{8'd0,   1'b0}},
    '{'{CMD_RESTART, 8'h00},  1'b0, '{8'd0,   1'b0}}
  };

  multilevel_error_diffusion_dither_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame size as the block sees it: zero acts as one, too large acts as max.
  function automatic int eff_dim(input logic [8:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return PIXEL_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  // Add one weighted share of the error to a stored neighbor, clamped.
  task automatic add_error_share(input int addr, input int wgt, input int err);
    int v;
    v = int'(pix_mem[addr]) + (wgt * err) / (1 << WGT_SHIFT);
    if (v < 0) v = 0;
    if (v > int'(PIXEL_MAX)) v = int'(PIXEL_MAX);
    pix_mem[addr] = 8'(v);
  endtask

  // Apply one accepted item to the model and return the level it yields.
  task automatic quantize_step(input cmd_item_t item, output bit made,
                               output res_item_t res);
    int cols, rows, total, addr, p, lo, hi, err;
    made = 1'b0;
    res = '0;
    cols = eff_dim(frame_cols, MAX_COLS);
    rows = eff_dim(frame_rows, MAX_ROWS);
    total = cols * rows;
    case (item.cmd)
      CMD_LOAD: begin
        if (load_pos >= total) load_pos = 0;
        pix_mem[load_pos] = item.pixel_value;
        ever_written[load_pos] = 1'b1;
        while (loaded_below < STORE_DEPTH && ever_written[loaded_below]) loaded_below++;
        load_pos++;
        if (load_pos >= total) load_pos = 0;
      end
      CMD_RESTART: begin
        load_pos = 0;
        proc_row = 0;
        proc_col = 0;
      end
      CMD_PROCESS: begin
        if (proc_row >= rows || proc_col >= cols) begin
          proc_row = 0;
          proc_col = 0;
        end
        addr = proc_row * cols + proc_col;
        p = pix_mem[addr];
        // Nearest level below and above; 0 and 255 are always levels.
        lo = p;
        hi = p;
        while (lo != 0 && lo != 255 && !level_set[lo]) lo--;
        while (hi != 0 && hi != 255 && !level_set[hi]) hi++;
        res.out_pixel = (p - lo < hi - p) ? lo[7:0] : hi[7:0];
        res.last_of_frame = (proc_row == rows - 1) && (proc_col == cols - 1);
        err = p - int'(res.out_pixel);
        // Spread the error to the neighbors that lie inside the frame.
        if (proc_col + 1 < cols) add_error_share(addr + 1, int'(WGT_RIGHT), err);
        if (proc_row + 1 < rows) begin
          if (proc_col >= 1) add_error_share(addr + cols - 1, int'(WGT_BELOW_LEFT), err);
          add_error_share(addr + cols, int'(WGT_BELOW), err);
          if (proc_col + 1 < cols) add_error_share(addr + cols + 1, int'(WGT_BELOW_RIGHT), err);
        end
        made = 1'b1;
        proc_col++;
        if (proc_col >= cols) begin
          proc_col = 0;
          proc_row++;
          if (proc_row >= rows) proc_row = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item after a random gap, wait for it to be taken, then predict.
  task automatic send_item(input cmd_item_t item, input bit pinned, input res_item_t want);
    int gap;
    bit made;
    res_item_t got;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data <= item;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    quantize_step(item, made, got);
    if (made) pending_levels.insert(pending_levels.size(), pinned ? want : got);
    if (item.cmd != CMD_NOP) items_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] pixel);
    send_item('{cmd, pixel}, 1'b0, '0);
  endtask

  // Stop offering items and wait until every expected level has arrived.
  task automatic drain(input int settle);
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  frame_cols = val[8:0];
      REG_HEIGHT: frame_rows = val[8:0];
      REG_MASK_0: level_set[0 +: CHUNK_BITS] = val;
      REG_MASK_1: level_set[CHUNK_BITS +: CHUNK_BITS] = val;
      REG_MASK_2: level_set[2 * CHUNK_BITS +: CHUNK_BITS] = val;
      REG_MASK_3: level_set[3 * CHUNK_BITS +: CHUNK_BITS] = val;
      default: ;
    endcase
  endtask

  // Result side: random stalls per item, and one long hold when requested.
  initial begin : result_sink
    int gap;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
          res_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (res_valid !== 1'b1);
    end
  end

  // Compare each accepted result with the oldest expected level.
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && res_ready) begin
      levels_checked++;
      if (res_data.last_of_frame === 1'b1) frame_ends++;
      if (pending_levels.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, level %0d", res_data.out_pixel));
      end else begin
        want = pending_levels.pop_front();
        if (res_data.out_pixel !== want.out_pixel)
          flag_mismatch($sformatf("out_pixel %0d, expected %0d",
                                  res_data.out_pixel, want.out_pixel));
        if (res_data.last_of_frame !== want.last_of_frame)
          flag_mismatch($sformatf("last_of_frame %0b, expected %0b",
                                  res_data.last_of_frame, want.last_of_frame));
      end
    end
  end

  // Stimulus: directed table, then phases of random frames and settings.
  initial begin : stimulus
    int phase, total, tail, n_proc, k;
    bit do_frame;
    logic [8:0] w_val, h_val;
    logic [63:0] mask_val;
    logic [1:0] kind;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on a 3x2 frame with one extra level at 100.
    write_reg(REG_WIDTH, 64'd3);
    write_reg(REG_HEIGHT, 64'd2);
    write_reg(REG_MASK_1, 64'd1 << 36);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);

    // Random phases; phases 3 to 5 use the largest and out-of-range sizes.
    phase = 0;
    while (phase < 6 || items_sent < ITEM_TARGET) begin
      drain(SETTLE);
      case (phase)
        1: begin
          w_val = 9'd4;
          h_val = 9'd3;
        end
        3: begin
          w_val = 9'd256;
          h_val = 9'd1;
        end
        4: begin
          w_val = 9'd0;
          h_val = 9'd511;
        end
        5: begin
          w_val = 9'd511;
          h_val = 9'd0;
        end
        default: begin
          w_val = 9'($urandom_range(1, 8));
          h_val = 9'($urandom_range(1, 8));
        end
      endcase
      write_reg(REG_WIDTH, 64'(w_val));
      write_reg(REG_HEIGHT, 64'(h_val));
      for (k = 0; k < CHUNK_COUNT; k++) begin
        if ((phase >= 3 && phase <= 5) || $urandom_range(0, 2) == 0) begin
          if (phase == 3) begin
            mask_val = '1;
          end else if (phase == 4) begin
            mask_val = '0;
          end else begin
            case ($urandom_range(0, 3))
              0: mask_val = '0;
              1: mask_val = '1;
              2: mask_val = {$urandom, $urandom};
              default: mask_val = {$urandom, $urandom} & {$urandom, $urandom} &
                                  {$urandom, $urandom};
            endcase
          end
          write_reg(REG_MASK_0 + 3'(k), mask_val);
        end
      end

      no_gaps = ($urandom_range(0, 3) == 0);
      // Phase 1 holds the result side off while items keep coming.
      if (phase == 1) begin
        no_gaps = 1'b1;
        hold_request = 1'b1;
      end

      // Well-formed frame: restart, load every pixel, then process them (24 if large).
      total = eff_dim(w_val, MAX_COLS) * eff_dim(h_val, MAX_ROWS);
      do_frame = (loaded_below < total) || (phase == 1) ||
                 (total <= SMALL_FRAME && $urandom_range(0, 3) != 0);
      if (do_frame) begin
        send_cmd(CMD_RESTART, pick_pixel());
        repeat (total) begin
          if ($urandom_range(0, 11) == 0) send_cmd(CMD_NOP, pick_pixel());
          send_cmd(CMD_LOAD, pick_pixel());
        end
        n_proc = (total > SMALL_FRAME) ? 24 : total;
        repeat (n_proc) begin
          if ($urandom_range(0, 11) == 0) send_cmd(CMD_NOP, pick_pixel());
          send_cmd(CMD_PROCESS, pick_pixel());
        end
      end

      // Mixed tail: stray loads, restarts and no-ops break up the sequence.
      tail = $urandom_range(5, 20);
      repeat (tail) begin
        if ($urandom_range(0, 9) == 0) drain(0);
        if (loaded_below < total) begin
          kind = CMD_LOAD;
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: kind = CMD_PROCESS;
            11, 12, 13, 14, 15: kind = CMD_LOAD;
            16, 17: kind = CMD_RESTART;
            default: kind = CMD_NOP;
          endcase
        end
        send_cmd(kind, pick_pixel());
      end
      phase++;
    end

    drain(SETTLE);
    $display("Ran %0d items over %0d register settings, including zero and oversize frames.",
             items_sent, phase + 1);
    $display("Checked %0d quantized levels, %0d of them frame ends; %0d mismatches.",
             levels_checked, frame_ends, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d levels still expected.", pending_levels.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
